@@ rtl/sit_pkg.sv @@
package sit_pkg;

    // Width of every coordinate field on the input channel.
    localparam int FIELD_WIDTH = 32;

    typedef logic signed [FIELD_WIDTH-1:0] field_t;

    // Orientation codes of a point against a directed line.
    typedef enum logic [1:0] {
        ORIENT_COLLINEAR = 2'd0,
        ORIENT_POSITIVE  = 2'd1,
        ORIENT_NEGATIVE  = 2'd2
    } orient_t;

endpackage

@@ rtl/sit_in_if.sv @@
interface sit_in_if;

    logic              valid;
    logic              ready;
    sit_pkg::field_t   seg_a_start_x;
    sit_pkg::field_t   seg_a_start_y;
    sit_pkg::field_t   seg_a_end_x;
    sit_pkg::field_t   seg_a_end_y;
    sit_pkg::field_t   seg_b_start_x;
    sit_pkg::field_t   seg_b_start_y;
    sit_pkg::field_t   seg_b_end_x;
    sit_pkg::field_t   seg_b_end_y;

    modport source (
        output valid,
        input  ready,
        output seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
        output seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y
    );

    modport sink (
        input  valid,
        output ready,
        input  seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
        input  seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y
    );

endinterface

@@ rtl/sit_out_if.sv @@
interface sit_out_if;

    logic valid;
    logic ready;
    logic segments_meet;

    modport source (
        output valid,
        input  ready,
        output segments_meet
    );

    modport sink (
        input  valid,
        output ready,
        input  segments_meet
    );

endinterface

@@ rtl/segment_intersection_test_unit.sv @@
// Closed line segment intersection test. Each input beat carries the endpoints
// of segments A and B; each output beat carries segments_meet, set when the two
// closed segments share at least one point (touching, collinear overlap and
// degenerate point segments included). Only the low COORD_WIDTH bits of each
// coordinate field are used, as a two's complement value. Cross products are
// exact, so no input pattern overflows. The block is a pipeline of three
// register stages (differences and box compares, the eight (COORD_WIDTH+1)-bit
// multipliers, product compare and final decision) and accepts a new pair every
// cycle unless a stall on the output side has filled the pipeline.
// Each stage moves on when the stage after it is empty or moving, so a stall
// on the output side holds the pipeline without loss or repetition.
module segment_intersection_test_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    sit_in_if.sink    pairs,
    sit_out_if.source results
);

    import sit_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DW-1:0]          diff_t;
    typedef logic signed [PW-1:0]          prod_t;

    // Endpoints, trimmed to the coordinate width.
    coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

    // Per orientation test k: point r against line p -> q.
    coord_t px [4];
    coord_t py [4];
    coord_t qx [4];
    coord_t qy [4];
    coord_t rx [4];
    coord_t ry [4];

    diff_t  da [4];
    diff_t  db [4];
    diff_t  dc [4];
    diff_t  dd [4];
    logic   box [4];

    logic   s1_ready;
    logic   s2_ready;
    logic   s3_ready;

    logic   s1_valid_reg;
    diff_t  s1_da_reg [4];
    diff_t  s1_db_reg [4];
    diff_t  s1_dc_reg [4];
    diff_t  s1_dd_reg [4];
    logic   s1_box_reg [4];

    logic   s2_valid_reg;
    prod_t  s2_pa_reg [4];
    prod_t  s2_pb_reg [4];
    logic   s2_box_reg [4];

    logic   s3_valid_reg;
    logic   s3_meet_reg;

    orient_t orient [4];
    logic    meet_next;

    assign ax0 = coord_t'(pairs.seg_a_start_x[COORD_WIDTH-1:0]);
    assign ay0 = coord_t'(pairs.seg_a_start_y[COORD_WIDTH-1:0]);
    assign ax1 = coord_t'(pairs.seg_a_end_x[COORD_WIDTH-1:0]);
    assign ay1 = coord_t'(pairs.seg_a_end_y[COORD_WIDTH-1:0]);
    assign bx0 = coord_t'(pairs.seg_b_start_x[COORD_WIDTH-1:0]);
    assign by0 = coord_t'(pairs.seg_b_start_y[COORD_WIDTH-1:0]);
    assign bx1 = coord_t'(pairs.seg_b_end_x[COORD_WIDTH-1:0]);
    assign by1 = coord_t'(pairs.seg_b_end_y[COORD_WIDTH-1:0]);

    // Tests 0,1: B endpoints against A. Tests 2,3: A endpoints against B.
    always_comb
    begin
        px[0] = ax0; py[0] = ay0; qx[0] = ax1; qy[0] = ay1; rx[0] = bx0; ry[0] = by0;
        px[1] = ax0; py[1] = ay0; qx[1] = ax1; qy[1] = ay1; rx[1] = bx1; ry[1] = by1;
        px[2] = bx0; py[2] = by0; qx[2] = bx1; qy[2] = by1; rx[2] = ax0; ry[2] = ay0;
        px[3] = bx0; py[3] = by0; qx[3] = bx1; qy[3] = by1; rx[3] = ax1; ry[3] = ay1;
    end

    // cross = (qy-py)*(rx-qx) - (qx-px)*(ry-qy); box: r inside bbox of p, q
    for (genvar k = 0; k < 4; k++)
    begin : g_stage1
        assign da[k] = DW'(qy[k]) - DW'(py[k]);
        assign db[k] = DW'(rx[k]) - DW'(qx[k]);
        assign dc[k] = DW'(qx[k]) - DW'(px[k]);
        assign dd[k] = DW'(ry[k]) - DW'(qy[k]);
        assign box[k] = (rx[k] <= px[k] || rx[k] <= qx[k]) &&
                        (rx[k] >= px[k] || rx[k] >= qx[k]) &&
                        (ry[k] <= py[k] || ry[k] <= qy[k]) &&
                        (ry[k] >= py[k] || ry[k] >= qy[k]);
    end

    // Stage 3: sign of the cross product from comparing the two products.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (s2_pa_reg[k] > s2_pb_reg[k])
            begin
                orient[k] = ORIENT_POSITIVE;
            end
            else if (s2_pa_reg[k] < s2_pb_reg[k])
            begin
                orient[k] = ORIENT_NEGATIVE;
            end
            else
            begin
                orient[k] = ORIENT_COLLINEAR;
            end
        end
        meet_next = ((orient[0] != orient[1]) && (orient[2] != orient[3])) ||
                    ((orient[0] == ORIENT_COLLINEAR) && s2_box_reg[0]) ||
                    ((orient[1] == ORIENT_COLLINEAR) && s2_box_reg[1]) ||
                    ((orient[2] == ORIENT_COLLINEAR) && s2_box_reg[2]) ||
                    ((orient[3] == ORIENT_COLLINEAR) && s2_box_reg[3]);
    end

    // A stage takes a new beat when it is empty or its content moves on.
    assign s3_ready    = !s3_valid_reg || results.ready;
    assign s2_ready    = !s2_valid_reg || s3_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign pairs.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pairs.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && pairs.valid)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s1_da_reg[k]  <= da[k];
                s1_db_reg[k]  <= db[k];
                s1_dc_reg[k]  <= dc[k];
                s1_dd_reg[k]  <= dd[k];
                s1_box_reg[k] <= box[k];
            end
        end
        if (s2_ready && s1_valid_reg)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s2_pa_reg[k]  <= PW'(s1_da_reg[k]) * PW'(s1_db_reg[k]);
                s2_pb_reg[k]  <= PW'(s1_dc_reg[k]) * PW'(s1_dd_reg[k]);
                s2_box_reg[k] <= s1_box_reg[k];
            end
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_meet_reg <= meet_next;
        end
    end

    assign results.valid         = s3_valid_reg;
    assign results.segments_meet = s3_meet_reg;

endmodule
